FILE: rtl/xxt_pkg.sv
// Shared types, constants and the mixing function of the XXTEA cipher pipeline.
// No dependencies; used by xxt_stage, xxtea_block_cipher_top and xxt_checker.
`timescale 1ns / 1ps

package xxt_pkg;

   // Block and key geometry
   localparam int DEFAULT_BLOCK_WORDS = 4;
   localparam int IO_WORDS            = 4;
   localparam int KEY_WORDS           = 4;
   localparam int CSR_INDEX_W         = 2;

   localparam logic [31:0] DELTA = 32'h9e37_79b9;

   typedef logic [31:0] word_type;
   typedef logic [KEY_WORDS-1:0][31:0] key_type;

   // Configuration register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_KEY_WORD0 = 2'd0,
      CSR_KEY_WORD1 = 2'd1,
      CSR_KEY_WORD2 = 2'd2,
      CSR_KEY_WORD3 = 2'd3
   } csr_index_type;

   // Operation codes
   localparam logic OP_ENCRYPT = 1'b0;
   localparam logic OP_DECRYPT = 1'b1;

   typedef struct packed {
      logic     operation;
      word_type in_word0;
      word_type in_word1;
      word_type in_word2;
      word_type in_word3;
   } req_type;

   typedef struct packed {
      word_type out_word0;
      word_type out_word1;
      word_type out_word2;
      word_type out_word3;
   } rsp_type;

   // Control that travels with each pipeline slot
   typedef struct packed {
      logic valid;
      logic op;
   } stage_ctl_type;

   // Standard XXTEA MX function, key word already selected
   function automatic word_type mix(input word_type y, input word_type z,
                                    input word_type sum, input word_type key);
      word_type a;
      word_type b;
      a = ((z >> 5) ^ (y << 2)) + ((y >> 3) ^ (z << 4));
      b = (sum ^ y) + (key ^ z);
      return a ^ b;
   endfunction

endpackage

FILE: rtl/xxt_stage.sv
// One word update of the XXTEA schedule, encrypt or decrypt per transaction.
// Depends on xxt_pkg; instantiated once per step by xxtea_block_cipher_top.
`timescale 1ns / 1ps

module xxt_stage #(
   parameter int BLOCK_WORDS = xxt_pkg::DEFAULT_BLOCK_WORDS,
   parameter int ROUNDS      = 6 + 52 / xxt_pkg::DEFAULT_BLOCK_WORDS,
   parameter int STEP        = 0
) (
   input  logic                                clock,
   input  logic                                reset,
   input  xxt_pkg::key_type                    key,
   input  xxt_pkg::stage_ctl_type              ctl_up,
   input  logic [BLOCK_WORDS-1:0][31:0]        words_up,
   output xxt_pkg::stage_ctl_type              ctl_down,
   output logic [BLOCK_WORDS-1:0][31:0]        words_down
);
   import xxt_pkg::*;

   localparam int IW = $clog2(BLOCK_WORDS);
   localparam int R  = STEP / BLOCK_WORDS;
   localparam int J  = STEP % BLOCK_WORDS;

   // Encrypt: round R, word J, sum counts up from one delta
   localparam logic [63:0]   ENC_PROD = 64'(R + 1) * 64'(DELTA);
   localparam logic [31:0]   ENC_SUM  = ENC_PROD[31:0];
   localparam logic [1:0]    ENC_KEY  = 2'(J & 3) ^ ENC_SUM[3:2];
   localparam logic [IW-1:0] ENC_P    = IW'(J);
   localparam logic [IW-1:0] ENC_Y    = IW'((J + 1) % BLOCK_WORDS);
   localparam logic [IW-1:0] ENC_Z    = IW'((J + BLOCK_WORDS - 1) % BLOCK_WORDS);

   // Decrypt: words taken from the top down, sum counts down from ROUNDS*delta
   localparam int            DP       = BLOCK_WORDS - 1 - J;
   localparam logic [63:0]   DEC_PROD = 64'(ROUNDS - R) * 64'(DELTA);
   localparam logic [31:0]   DEC_SUM  = DEC_PROD[31:0];
   localparam logic [1:0]    DEC_KEY  = 2'(DP & 3) ^ DEC_SUM[3:2];
   localparam logic [IW-1:0] DEC_P    = IW'(DP);
   localparam logic [IW-1:0] DEC_Y    = IW'((DP + 1) % BLOCK_WORDS);
   localparam logic [IW-1:0] DEC_Z    = IW'((DP + BLOCK_WORDS - 1) % BLOCK_WORDS);

   stage_ctl_type                   ctl_ff;
   stage_ctl_type                   ctl_in;
   logic [BLOCK_WORDS-1:0][31:0]    words_ff;
   logic [BLOCK_WORDS-1:0][31:0]    words_in;

   word_type      y;
   word_type      z;
   word_type      sum;
   word_type      key_sel;
   word_type      mx;
   word_type      target;
   word_type      updated;
   logic [IW-1:0] target_idx;
   logic          dec;

   // Operand selection and the mix
   always_comb begin
      dec        = (ctl_up.op == OP_DECRYPT);
      y          = dec ? words_up[DEC_Y] : words_up[ENC_Y];
      z          = dec ? words_up[DEC_Z] : words_up[ENC_Z];
      sum        = dec ? DEC_SUM : ENC_SUM;
      key_sel    = dec ? key[DEC_KEY] : key[ENC_KEY];
      target_idx = dec ? DEC_P : ENC_P;
      target     = words_up[target_idx];
      mx         = mix(y, z, sum, key_sel);
      updated    = dec ? (target - mx) : (target + mx);
   end

   // Replace the updated word, pass the rest
   always_comb begin
      words_in             = words_up;
      words_in[target_idx] = updated;
      ctl_in               = ctl_up;
   end

   // Stage register; only the valid bit is reset
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.valid <= 1'b0;
      end else begin
         ctl_ff.valid <= ctl_in.valid;
      end
      ctl_ff.op <= ctl_in.op;
      words_ff  <= words_in;
   end

   assign ctl_down   = ctl_ff;
   assign words_down = words_ff;

endmodule

FILE: rtl/xxtea_block_cipher_top.sv
// XXTEA block cipher: fully unrolled pipeline, one register stage per word update.
// Throughput: one block per cycle outside reset; the chain of word-update stages sets the latency.
// Reset (synchronous, active high) clears the slot valid bits and the key to zero.
// busy is high only during reset; results appear as one-cycle strobes, no back-pressure.
`timescale 1ns / 1ps

module xxtea_block_cipher_top #(
   parameter int BLOCK_WORDS = xxt_pkg::DEFAULT_BLOCK_WORDS
) (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             start,
   output logic                             busy,
   input  xxt_pkg::req_type                 req_payload,
   // result channel
   output logic                             rsp_valid,
   output xxt_pkg::rsp_type                 rsp_payload,
   // register write channel
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [xxt_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [31:0]                      csr_wdata
);
   import xxt_pkg::*;

   localparam int ROUNDS = 6 + 52 / BLOCK_WORDS;
   localparam int STEPS  = ROUNDS * BLOCK_WORDS;

   key_type                         key_ff;
   key_type                         key_in;
   stage_ctl_type                   ctl   [0:STEPS];
   logic [BLOCK_WORDS-1:0][31:0]    words [0:STEPS];
   logic [IO_WORDS-1:0][31:0]       io_in;
   logic [IO_WORDS-1:0][31:0]       io_out;

   // Key registers
   always_comb begin
      key_in = key_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_KEY_WORD0: key_in[0] = csr_wdata;
            CSR_KEY_WORD1: key_in[1] = csr_wdata;
            CSR_KEY_WORD2: key_in[2] = csr_wdata;
            CSR_KEY_WORD3: key_in[3] = csr_wdata;
            default:       key_in    = key_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
      end else begin
         key_ff <= key_in;
      end
   end

   assign csr_ready = 1'b1;
   assign busy      = reset;

   // Pipeline entry: block words beyond the request fields enter as zero
   assign io_in[0] = req_payload.in_word0;
   assign io_in[1] = req_payload.in_word1;
   assign io_in[2] = req_payload.in_word2;
   assign io_in[3] = req_payload.in_word3;

   assign ctl[0].valid = start && !busy;
   assign ctl[0].op    = req_payload.operation;

   for (genvar i = 0; i < BLOCK_WORDS; i++) begin : g_entry
      if (i < IO_WORDS) begin : g_io
         assign words[0][i] = io_in[i];
      end else begin : g_pad
         assign words[0][i] = '0;
      end
   end

   // Word-update stages
   for (genvar s = 0; s < STEPS; s++) begin : g_step
      xxt_stage #(
         .BLOCK_WORDS (BLOCK_WORDS),
         .ROUNDS      (ROUNDS),
         .STEP        (s)
      ) u_stage (
         .clock      (clock),
         .reset      (reset),
         .key        (key_ff),
         .ctl_up     (ctl[s]),
         .words_up   (words[s]),
         .ctl_down   (ctl[s+1]),
         .words_down (words[s+1])
      );
   end

   // Result: output fields beyond the block read as zero
   for (genvar i = 0; i < IO_WORDS; i++) begin : g_exit
      if (i < BLOCK_WORDS) begin : g_blk
         assign io_out[i] = words[STEPS][i];
      end else begin : g_zero
         assign io_out[i] = '0;
      end
   end

   assign rsp_valid             = ctl[STEPS].valid;
   assign rsp_payload.out_word0 = io_out[0];
   assign rsp_payload.out_word1 = io_out[1];
   assign rsp_payload.out_word2 = io_out[2];
   assign rsp_payload.out_word3 = io_out[3];

endmodule

FILE: rtl/xxt_checker.sv
// Port-level checks for xxtea_block_cipher_top, attached with a bind.
// Depends on xxt_pkg for the channel types.
`timescale 1ns / 1ps

module xxt_port_props #(
   parameter int BLOCK_WORDS = xxt_pkg::DEFAULT_BLOCK_WORDS
) (
   input logic                             clock,
   input logic                             reset,
   input logic                             start,
   input logic                             busy,
   input logic                             rsp_valid,
   input logic                             csr_ready
);
   import xxt_pkg::*;

   localparam int LATENCY = (6 + 52 / BLOCK_WORDS) * BLOCK_WORDS;

   // Every accepted transaction is followed by a result strobe
   a_accept_to_rsp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_valid)
      else $error("accepted transaction produced no result");

   // Every strobe traces back to an earlier accept
   a_rsp_from_accept: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LATENCY))
      else $error("result without a matching transaction");

   // Pipeline is empty right after reset
   a_reset_flush: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result strobe right after reset");

   // Out of reset the block always takes requests and register writes
   a_always_ready: assert property (@(posedge clock) disable iff (reset)
      !busy && csr_ready)
      else $error("block stalled a channel outside reset");

endmodule

bind xxtea_block_cipher_top xxt_port_props #(
   .BLOCK_WORDS (BLOCK_WORDS)
) u_xxt_port_props (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .csr_ready (csr_ready)
);

FILE: test/xxt_checker.sv
// Checker for the XXTEA block cipher: watches the request, result and register channels.
// Predicts each result from its own copy of the key and compares field by field.
// Depends on xxt_pkg for the channel payload types and register indexes.
`timescale 1ns / 1ps

module xxt_checker #(
   parameter int BLOCK_WORDS = xxt_pkg::DEFAULT_BLOCK_WORDS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic                            busy,
   input  xxt_pkg::req_type                req_payload,
   input  logic                            rsp_valid,
   input  xxt_pkg::rsp_type                rsp_payload,
   input  logic                            csr_valid,
   input  logic                            csr_ready,
   input  logic [xxt_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [31:0]                     csr_wdata,
   output int                              mismatch_count,
   output int                              checked_count,
   output int                              outstanding
);
   import xxt_pkg::*;

   localparam int ROUNDS = 6 + 52 / BLOCK_WORDS;

   rsp_type expected_blocks[$];
   key_type key_shadow;
   int      errors;
   int      checked;

   assign mismatch_count = errors;
   assign checked_count  = checked;

   // MX term of one word update
   function automatic word_type round_mix(word_type y, word_type z, word_type sum,
                                          word_type kw);
      word_type lhs;
      word_type rhs;
      lhs = ((z >> 5) ^ (y << 2)) + ((y >> 3) ^ (z << 4));
      rhs = (sum ^ y) + (kw ^ z);
      return lhs ^ rhs;
   endfunction

   // Full encrypt or decrypt of one block under the given key
   function automatic rsp_type cipher_block(req_type r, key_type k);
      word_type   v[BLOCK_WORDS];
      word_type   in_w[IO_WORDS];
      word_type   out_w[IO_WORDS];
      word_type   sum;
      word_type   y;
      word_type   z;
      logic [1:0] e;
      logic [1:0] sel;
      rsp_type    res;
      in_w[0] = r.in_word0;
      in_w[1] = r.in_word1;
      in_w[2] = r.in_word2;
      in_w[3] = r.in_word3;
      // words beyond the four inputs enter as zero
      for (int i = 0; i < BLOCK_WORDS; i++)
         v[i] = (i < IO_WORDS) ? in_w[i] : '0;
      if (r.operation == OP_DECRYPT) begin
         sum = '0;
         for (int i = 0; i < ROUNDS; i++)
            sum = sum + DELTA;
         y = v[0];
         for (int rnd = 0; rnd < ROUNDS; rnd++) begin
            e = sum[3:2];
            for (int p = BLOCK_WORDS - 1; p > 0; p--) begin
               z    = v[p-1];
               sel  = 2'(p) ^ e;
               v[p] = v[p] - round_mix(y, z, sum, k[sel]);
               y    = v[p];
            end
            z    = v[BLOCK_WORDS-1];
            v[0] = v[0] - round_mix(y, z, sum, k[e]);
            y    = v[0];
            sum  = sum - DELTA;
         end
      end else begin
         sum = '0;
         z   = v[BLOCK_WORDS-1];
         for (int rnd = 0; rnd < ROUNDS; rnd++) begin
            sum = sum + DELTA;
            e   = sum[3:2];
            for (int p = 0; p < BLOCK_WORDS - 1; p++) begin
               y    = v[p+1];
               sel  = 2'(p) ^ e;
               v[p] = v[p] + round_mix(y, z, sum, k[sel]);
               z    = v[p];
            end
            y   = v[0];
            sel = 2'(BLOCK_WORDS - 1) ^ e;
            v[BLOCK_WORDS-1] = v[BLOCK_WORDS-1] + round_mix(y, z, sum, k[sel]);
            z   = v[BLOCK_WORDS-1];
         end
      end
      // outputs beyond the block come back as zero
      for (int i = 0; i < IO_WORDS; i++)
         out_w[i] = (i < BLOCK_WORDS) ? v[i] : '0;
      res.out_word0 = out_w[0];
      res.out_word1 = out_w[1];
      res.out_word2 = out_w[2];
      res.out_word3 = out_w[3];
      return res;
   endfunction

   task automatic check_word(input string field, input word_type want, input word_type got);
      if (got !== want) begin
         $display("%0t ERROR %s expected %h actual %h", $time, field, want, got);
         errors++;
      end
   endtask

   // Sample all channels at the clock edge: results first, then new requests, then key writes
   always @(posedge clock) begin : monitor
      rsp_type want;
      if (reset) begin
         expected_blocks.delete();
         key_shadow = '0;
         errors     = 0;
         checked    = 0;
      end else begin
         if (rsp_valid) begin
            if (expected_blocks.size() == 0) begin
               $display("%0t ERROR result with none expected: actual %h", $time, rsp_payload);
               errors++;
            end else begin
               want = expected_blocks.pop_front();
               check_word("out_word0", want.out_word0, rsp_payload.out_word0);
               check_word("out_word1", want.out_word1, rsp_payload.out_word1);
               check_word("out_word2", want.out_word2, rsp_payload.out_word2);
               check_word("out_word3", want.out_word3, rsp_payload.out_word3);
               checked++;
            end
         end
         if (start && !busy)
            expected_blocks.push_back(cipher_block(req_payload, key_shadow));
         if (csr_valid && csr_ready)
            key_shadow[csr_index] = csr_wdata;
      end
      outstanding <= expected_blocks.size();
   end

endmodule

FILE: test/xxtea_block_cipher_top_tb.sv
// Testbench top for the XXTEA block cipher: drives blocks and key writes, gives the verdict.
// Depends on xxt_pkg, xxtea_block_cipher_top and xxt_checker.
`timescale 1ns / 1ps

module xxtea_block_cipher_top_tb;
   import xxt_pkg::*;

   localparam int BLOCK_WORDS  = DEFAULT_BLOCK_WORDS;
   localparam int DRAIN_CYCLES = 100;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int SEGMENTS     = 6;
   localparam int SEG_ITEMS    = 96;

   logic                   clock;
   logic                   reset;
   logic                   start;
   logic                   busy;
   req_type                req_payload;
   logic                   rsp_valid;
   rsp_type                rsp_payload;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [31:0]            csr_wdata;

   int mismatch_count;
   int checked_count;
   int outstanding;
   int cycle_count;
   int idle_pct;
   int blocks_sent;
   int decrypt_sent;
   int key_settings;

   xxtea_block_cipher_top #(.BLOCK_WORDS(BLOCK_WORDS)) DUT (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   xxt_checker #(.BLOCK_WORDS(BLOCK_WORDS)) cipher_checker (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_payload    (req_payload),
      .rsp_valid      (rsp_valid),
      .rsp_payload    (rsp_payload),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .checked_count  (checked_count),
      .outstanding    (outstanding)
   );

   always #5 clock = ~clock;

   // Hard stop if the run hangs
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d results still due", cycle_count, outstanding);
         $display("** xxtea_block_cipher_top: FAILED **");
         $finish;
      end
   end

   function automatic req_type make_block(logic op, word_type w0, word_type w1,
                                          word_type w2, word_type w3);
      req_type r;
      r.operation = op;
      r.in_word0  = w0;
      r.in_word1  = w1;
      r.in_word2  = w2;
      r.in_word3  = w3;
      return r;
   endfunction

   // Mostly uniform words, with edge values mixed in
   function automatic word_type pick_word();
      case ($urandom_range(19))
         0:       return 32'h0000_0000;
         1:       return 32'hffff_ffff;
         2:       return 32'h8000_0000;
         3:       return 32'h0000_0001;
         default: return $urandom;
      endcase
   endfunction

   // One register transaction; waits for the handshake
   task automatic write_reg(input csr_index_type idx, input word_type value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic load_key(input word_type k0, input word_type k1,
                           input word_type k2, input word_type k3);
      write_reg(CSR_KEY_WORD0, k0);
      write_reg(CSR_KEY_WORD1, k1);
      write_reg(CSR_KEY_WORD2, k2);
      write_reg(CSR_KEY_WORD3, k3);
      key_settings++;
   endtask

   // One block transaction, with random idle cycles ahead of it
   task automatic send_block(input req_type r);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start       <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (busy);
      blocks_sent++;
      if (r.operation == OP_DECRYPT)
         decrypt_sent++;
   endtask

   // Wait until every block sent so far has come back
   task automatic wait_idle();
      start <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic run_directed();
      send_block(make_block(OP_ENCRYPT, '0, '0, '0, '0));
      send_block(make_block(OP_DECRYPT, '0, '0, '0, '0));
      send_block(make_block(OP_ENCRYPT, '1, '1, '1, '1));
      send_block(make_block(OP_DECRYPT, '1, '1, '1, '1));
      send_block(make_block(OP_ENCRYPT, 32'h8000_0000, 32'h8000_0000,
                            32'h8000_0000, 32'h8000_0000));
      send_block(make_block(OP_DECRYPT, 32'h0000_0001, 32'h0000_0001,
                            32'h0000_0001, 32'h0000_0001));
      send_block(make_block(OP_ENCRYPT, 32'haaaa_aaaa, 32'h5555_5555,
                            32'haaaa_aaaa, 32'h5555_5555));
      send_block(make_block(OP_DECRYPT, 32'h5555_5555, 32'haaaa_aaaa,
                            32'h5555_5555, 32'haaaa_aaaa));
      send_block(make_block(OP_ENCRYPT, '0, '0, '0, '1));
      send_block(make_block(OP_DECRYPT, '1, '0, '0, '0));
   endtask

   initial begin
      clock        = 1'b0;
      reset        = 1'b1;
      start        = 1'b0;
      req_payload  = '0;
      csr_valid    = 1'b0;
      csr_index    = CSR_KEY_WORD0;
      csr_wdata    = '0;
      cycle_count  = 0;
      idle_pct     = 33;
      blocks_sent  = 0;
      decrypt_sent = 0;
      key_settings = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed blocks under the all-zero and all-ones keys
      load_key('0, '0, '0, '0);
      run_directed();
      wait_idle();
      load_key('1, '1, '1, '1);
      run_directed();
      wait_idle();

      // Random segments, fresh key each; idle rate 33, then 82, then none
      for (int seg = 0; seg < SEGMENTS; seg++) begin
         if (seg == 1)
            load_key(32'h0000_0000, 32'hffff_ffff, 32'h8000_0000, 32'h0000_0001);
         else
            load_key($urandom, $urandom, $urandom, $urandom);
         idle_pct = (seg < 2) ? 33 : (seg < 4) ? 82 : 0;
         for (int n = 0; n < SEG_ITEMS; n++)
            send_block(make_block($urandom_range(1) ? OP_DECRYPT : OP_ENCRYPT,
                                  pick_word(), pick_word(), pick_word(), pick_word()));
         wait_idle();
      end

      // Let the pipeline run empty; any stray result is flagged by the checker
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run covered %0d blocks (%0d decrypt) under %0d keys, idle rates 33/82/0 pct",
               blocks_sent, decrypt_sent, key_settings);
      $display("Results checked: %0d, mismatches: %0d", checked_count, mismatch_count);
      if (mismatch_count == 0)
         $display("** xxtea_block_cipher_top: PASSED **");
      else
         $display("** xxtea_block_cipher_top: FAILED **");
      $finish;
   end

endmodule
